[rtl/nlp_pkg.sv]
// Shared types and character constants for the numeric literal parser.
`timescale 1ns / 1ps
`default_nettype none

package nlp_pkg;

    // Parser phase within one literal
    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_MINUS     = 3'd1,
        PH_ZERO      = 3'd2,
        PH_HEX_EMPTY = 3'd3,
        PH_BIN_EMPTY = 3'd4,
        PH_DEC       = 3'd5,
        PH_HEX       = 3'd6,
        PH_BIN       = 3'd7
    } nlp_phase_t;

    // Running state carried from character to character
    typedef struct packed {
        logic [31:0] acc;
        nlp_phase_t  phase;
        logic        minus;
        logic        err;
    } nlp_state_t;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_B  = 8'h62;

    localparam nlp_state_t STATE_CLEAR = '{acc: 32'd0, phase: PH_START, minus: 1'b0,
                                           err: 1'b0};

endpackage : nlp_pkg

`default_nettype wire

[rtl/nlp_in_stage.sv]
// Input register stage: captures one character transaction per cycle while its slot is free.
`timescale 1ns / 1ps
`default_nettype none

module nlp_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    input  wire logic       s_is_final,
    input  wire logic       advance,
    output logic            in_valid,
    output logic [7:0]      in_char,
    output logic            in_final
);
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       final_reg;

    // Slot frees up when empty or when the downstream stage consumes it
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            char_reg  <= s_char_code;
            final_reg <= s_is_final;
        end
    end

    assign in_valid = valid_reg;
    assign in_char  = char_reg;
    assign in_final = final_reg;

endmodule : nlp_in_stage

`default_nettype wire

[rtl/nlp_char_step.sv]
// Per-character parser update and end-of-literal result formation.
`timescale 1ns / 1ps
`default_nettype none

module nlp_char_step (
    input  wire nlp_pkg::nlp_state_t state_cur,
    input  wire logic [7:0]          char_code,
    output nlp_pkg::nlp_state_t      state_step,
    output logic [31:0]              res_value,
    output logic                     res_ok
);
    import nlp_pkg::*;

    logic        is_dec;
    logic        is_hex;
    logic        is_bin;
    logic [3:0]  hex_val;
    logic [31:0] acc_dec;
    logic [31:0] acc_hex;
    logic [31:0] acc_bin;
    logic [31:0] acc_signed;
    logic        bad;

    // Digit classification
    assign is_dec  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_bin  = (char_code == CH_ZERO) || (char_code == CH_ONE);
    assign is_hex  = is_dec
                   || ((char_code >= CH_LC_A) && (char_code <= CH_LC_F))
                   || ((char_code >= CH_UC_A) && (char_code <= CH_UC_F));
    // Letters a-f and A-F both have low nibble 1..6; adding 9 gives 10..15
    assign hex_val = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);

    // Shift-add accumulator updates, modulo 2^32
    assign acc_dec = {state_cur.acc[28:0], 3'b000} + {state_cur.acc[30:0], 1'b0}
                   + {28'd0, char_code[3:0]};
    assign acc_hex = {state_cur.acc[27:0], hex_val};
    assign acc_bin = {state_cur.acc[30:0], char_code[0]};

    // Phase transition
    always_comb begin
        state_step = state_cur;
        unique case (state_cur.phase)
            PH_START, PH_MINUS: begin
                if ((state_cur.phase == PH_START) && (char_code == CH_MINUS)) begin
                    state_step.minus = 1'b1;
                    state_step.phase = PH_MINUS;
                end else if (char_code == CH_ZERO) begin
                    state_step.acc   = 32'd0;
                    state_step.phase = PH_ZERO;
                end else begin
                    state_step.phase = PH_DEC;
                    if (is_dec) begin
                        state_step.acc = {28'd0, char_code[3:0]};
                    end else begin
                        state_step.acc = 32'd0;
                        state_step.err = 1'b1;
                    end
                end
            end
            PH_ZERO: begin
                if (char_code == CH_LC_X) begin
                    state_step.phase = PH_HEX_EMPTY;
                end else if (char_code == CH_LC_B) begin
                    state_step.phase = PH_BIN_EMPTY;
                end else begin
                    state_step.phase = PH_DEC;
                    if (is_dec) state_step.acc = acc_dec;
                    else        state_step.err = 1'b1;
                end
            end
            PH_HEX_EMPTY, PH_HEX: begin
                state_step.phase = PH_HEX;
                if (is_hex) state_step.acc = acc_hex;
                else        state_step.err = 1'b1;
            end
            PH_BIN_EMPTY, PH_BIN: begin
                state_step.phase = PH_BIN;
                if (is_bin) state_step.acc = acc_bin;
                else        state_step.err = 1'b1;
            end
            PH_DEC: begin
                if (is_dec) state_step.acc = acc_dec;
                else        state_step.err = 1'b1;
            end
            default: begin
                state_step = state_cur;
            end
        endcase
    end

    // Result as it would be reported if this character is the last one
    assign bad = state_step.err
              || (state_step.phase == PH_START) || (state_step.phase == PH_MINUS)
              || (state_step.phase == PH_HEX_EMPTY) || (state_step.phase == PH_BIN_EMPTY);
    assign acc_signed = state_step.minus ? (32'd0 - state_step.acc) : state_step.acc;
    assign res_value  = bad ? 32'd0 : acc_signed;
    assign res_ok     = !bad;

endmodule : nlp_char_step

`default_nettype wire

[rtl/number_literal_parser.sv]
// Numeric literal parser (decimal, 0x hex, 0b binary, optional leading minus).
// Usage:
//   Input channel (s_valid/s_ready): one character per transaction in
//   s_char_code, with s_is_final high on the last character of a literal.
//   Result channel (m_valid/m_ready): one transaction per literal, carrying
//   m_value (modulo 2^32, two's complement when negative) and m_ok. An
//   invalid literal reports m_ok = 0 with m_value = 0.
// Throughput: one character per cycle while the result channel is not stalled,
//   set by the accumulator update (a 32-bit shift or shift-add) between the
//   input register and the parser state register.
// Path: the final character is captured in the input register, then its result
//   is registered in the result register, where m_valid rises.
// Stall: while a result waits on m_ready low, the result register holds and
//   the input register holds one more character; s_ready drops only when
//   both are occupied and the receiver is stalled.
// Reset: aresetn (synchronous, active low) empties both registers and
//   returns the parser to the start of a literal.
`timescale 1ns / 1ps
`default_nettype none

module number_literal_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_is_final,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_value,
    output logic             m_ok
);
    import nlp_pkg::*;

    logic        advance;
    logic        in_valid;
    logic [7:0]  in_char;
    logic        in_final;
    nlp_state_t  state_reg;
    nlp_state_t  state_next;
    nlp_state_t  state_step;
    logic [31:0] res_value;
    logic        res_ok;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [31:0] m_value_reg;
    logic        m_ok_reg;

    // Pipeline moves whenever the result register can take new data
    assign advance = !m_valid_reg || m_ready;

    nlp_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_final  (s_is_final),
        .advance     (advance),
        .in_valid    (in_valid),
        .in_char     (in_char),
        .in_final    (in_final)
    );

    nlp_char_step u_char_step (
        .state_cur  (state_reg),
        .char_code  (in_char),
        .state_step (state_step),
        .res_value  (res_value),
        .res_ok     (res_ok)
    );

    // Parser state: clears after the final character of each literal
    always_comb begin
        state_next = state_reg;
        if (in_valid && advance) begin
            state_next = in_final ? STATE_CLEAR : state_step;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = in_valid && in_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (advance && in_valid && in_final) begin
            m_value_reg <= res_value;
            m_ok_reg    <= res_ok;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_ok    = m_ok_reg;

    // A failed literal always reports a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_value == 32'd0))
        else $error("error result with nonzero value");

    // Parser returns to the start of a literal after each final character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_final && advance) |=> (state_reg.phase == PH_START))
        else $error("parser state not cleared after final character");

    // Back-pressure only when both registers are occupied and stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid && m_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    // A new result appears only from a final character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid && !in_final) |=> !m_valid_reg)
        else $error("result produced from a non-final character");

endmodule : number_literal_parser

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for number_literal_parser: directed and random literals.
`timescale 1ns / 1ps

module tb_top;
    import nlp_pkg::*;

    localparam int unsigned RANDOM_CHARS = 1350;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned MAX_WAIT     = 13;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [31:0] value;
        logic        ok;
    } literal_result_t;

    // Tracks parser state per character and the queue of expected results
    class literal_scoreboard;
        nlp_state_t      st;
        literal_result_t expected_q[$];
        int unsigned     mismatches;
        int unsigned     results_seen;
        int unsigned     ok_results;

        function new();
            st = STATE_CLEAR;
            mismatches = 0;
            results_seen = 0;
            ok_results = 0;
        endfunction

        task report(input string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function void dec_digit(input logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
                st.acc = st.acc * 32'd10 + {24'd0, c - CH_ZERO};
            else
                st.err = 1'b1;
        endfunction

        function void hex_digit(input logic [7:0] c);
            logic [7:0] d;
            if (c >= CH_ZERO && c <= CH_NINE)
                d = c - CH_ZERO;
            else if (c >= CH_LC_A && c <= CH_LC_F)
                d = c - CH_LC_A + 8'd10;
            else if (c >= CH_UC_A && c <= CH_UC_F)
                d = c - CH_UC_A + 8'd10;
            else begin
                st.err = 1'b1;
                return;
            end
            st.acc = {st.acc[27:0], d[3:0]};
        endfunction

        function void bin_digit(input logic [7:0] c);
            if (c == CH_ZERO || c == CH_ONE)
                st.acc = {st.acc[30:0], c[0]};
            else
                st.err = 1'b1;
        endfunction

        // First character of the body, after an optional minus
        function void body_first(input logic [7:0] c);
            st.acc = 32'd0;
            if (c == CH_ZERO) begin
                st.phase = PH_ZERO;
            end else begin
                st.phase = PH_DEC;
                dec_digit(c);
            end
        endfunction

        // Advance the parser by one accepted character
        function void note_char(input logic [7:0] c, input logic fin);
            literal_result_t r;
            logic bad;
            case (st.phase)
                PH_START: begin
                    if (c == CH_MINUS) begin
                        st.minus = 1'b1;
                        st.phase = PH_MINUS;
                    end else begin
                        body_first(c);
                    end
                end
                PH_MINUS: body_first(c);
                PH_ZERO: begin
                    if (c == CH_LC_X) begin
                        st.phase = PH_HEX_EMPTY;
                    end else if (c == CH_LC_B) begin
                        st.phase = PH_BIN_EMPTY;
                    end else begin
                        st.phase = PH_DEC;
                        dec_digit(c);
                    end
                end
                PH_HEX_EMPTY, PH_HEX: begin
                    st.phase = PH_HEX;
                    hex_digit(c);
                end
                PH_BIN_EMPTY, PH_BIN: begin
                    st.phase = PH_BIN;
                    bin_digit(c);
                end
                default: dec_digit(c);
            endcase
            if (fin) begin
                bad = st.err || st.phase == PH_MINUS || st.phase == PH_START ||
                      st.phase == PH_HEX_EMPTY || st.phase == PH_BIN_EMPTY;
                r.ok = !bad;
                r.value = bad ? 32'd0 : (st.minus ? 32'd0 - st.acc : st.acc);
                expected_q = {expected_q, r};
                st = STATE_CLEAR;
            end
        endfunction

        task check_result(input logic [31:0] value, input logic ok);
            literal_result_t r;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result value=%h ok=%b", value, ok));
            end else begin
                r = expected_q.pop_front();
                if (r.ok) ok_results++;
                if (value !== r.value)
                    report($sformatf("value %h, expected %h", value, r.value));
                if (ok !== r.ok)
                    report($sformatf("ok %b, expected %b", ok, r.ok));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        s_is_final;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_value;
    logic        m_ok;

    literal_scoreboard sb = new();

    logic [7:0]  lit_chars[$];
    int unsigned chars_sent = 0;
    int unsigned literals_sent = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    number_literal_parser u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .s_is_final  (s_is_final),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_ok        (m_ok)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitor both channels at each rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_char(s_char_code, s_is_final);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_value, m_ok);
    end

    // Watchdog: end the run if no transaction moves for too long
    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("[number_literal_parser] ERROR");
        $finish;
    end

    // Result side: random stalls before each result, with bursts of none
    initial begin : receiver
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Send one character; returns at the edge where it was accepted
    task send_char(input logic [7:0] c, input logic fin);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= c;
        s_is_final  <= fin;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
    endtask

    // Append one character to the literal being built
    task add_char(input logic [7:0] c);
        lit_chars = {lit_chars, c};
    endtask

    // Send lit_chars as one literal, final flag on the last character
    task send_literal();
        for (int i = 0; i < lit_chars.size(); i++)
            send_char(lit_chars[i], i == lit_chars.size() - 1);
        literals_sent++;
        lit_chars.delete();
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
        send_literal();
    endtask

    function logic [7:0] rand_dec();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function logic [7:0] rand_hex();
        int unsigned r;
        r = $urandom_range(0, 21);
        if (r < 10) return CH_ZERO + 8'(r);
        if (r < 16) return CH_LC_A + 8'(r - 10);
        return CH_UC_A + 8'(r - 16);
    endfunction

    // Well-formed literal: fmt 0 decimal, 1 hex, 2 binary
    task build_good(input int unsigned fmt);
        int unsigned len;
        if ($urandom_range(0, 2) == 0) add_char(CH_MINUS);
        case (fmt)
            0: begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                 : $urandom_range(1, 9);
                repeat (len) add_char(rand_dec());
            end
            1: begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12)
                                                 : $urandom_range(1, 8);
                add_char(CH_ZERO);
                add_char(CH_LC_X);
                repeat (len) add_char(rand_hex());
            end
            default: begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36)
                                                 : $urandom_range(1, 12);
                add_char(CH_ZERO);
                add_char(CH_LC_B);
                repeat (len) add_char(CH_ZERO + 8'($urandom_range(0, 1)));
            end
        endcase
    endtask

    // One random literal: mostly well-formed, the rest broken or noise
    task build_random();
        int unsigned kind;
        int unsigned pos;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            build_good(kind % 3);
        end else if (kind < 78) begin
            // bare prefix, empty body or uppercase prefix
            if ($urandom_range(0, 1) == 0) add_char(CH_MINUS);
            if ($urandom_range(0, 3) != 0) begin
                add_char(CH_ZERO);
                case ($urandom_range(0, 3))
                    0: add_char(CH_LC_X);
                    1: add_char(CH_LC_B);
                    2: add_char(CH_LC_X - 8'h20);
                    default: add_char(CH_LC_B - 8'h20);
                endcase
                if ($urandom_range(0, 1) == 0) add_char(rand_hex());
            end
            if (lit_chars.size() == 0) add_char(CH_MINUS);
        end else if (kind < 90) begin
            // well-formed literal with one character corrupted
            build_good($urandom_range(0, 2));
            pos = $urandom_range(0, lit_chars.size() - 1);
            lit_chars[pos] = ($urandom_range(0, 3) == 0) ? CH_MINUS
                                                         : 8'($urandom_range(0, 255));
        end else begin
            repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int unsigned random_start;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_char_code = 8'd0;
        s_is_final  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty body, bare and uppercase prefixes, each radix,
        // misplaced minus, byte extremes and decimal wraparound
        send_text("-");
        send_text("0x");
        send_text("-0b");
        send_text("0X1");
        send_text("0xaF");
        send_text("0b1");
        send_text("7-");
        send_text("-9");
        add_char(8'hff);
        send_literal();
        add_char(8'h00);
        send_literal();
        send_text("5000000000");

        // Random literals
        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS) begin
            build_random();
            send_literal();
        end
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d literals in %0d characters; %0d results checked, %0d valid",
                 literals_sent, chars_sent, sb.results_seen, sb.ok_results);
        $display("%0d mismatches, %0d results still expected",
                 sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("[number_literal_parser] OK");
        else
            $display("[number_literal_parser] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/nlp_pkg.sv
rtl/nlp_in_stage.sv
rtl/nlp_char_step.sv
rtl/number_literal_parser.sv
bench/tb_top.sv
